[sv/icgc_pkg.sv]
// Package for the icon grid scanline compositor: payload types, pipeline stage records,
// layout constants and small constant-table functions. Depends on nothing.
package icgc_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int COUNT_W    = 7;
    localparam int SCROLL_W   = 11;
    localparam int SEL_W      = 6;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int X_W        = 9;
    localparam int Y_W        = 8;
    localparam int COLOUR_W   = 16;
    localparam int ROWS_W     = $clog2((MAX_ITEMS + 2) / 3 + 1);

    localparam logic [COLOUR_W-1:0] COL_CELL   = 16'h320D;
    localparam logic [COLOUR_W-1:0] COL_TRACK  = 16'h2145;
    localparam logic [COLOUR_W-1:0] COL_THUMB  = 16'h8410;
    localparam logic [COLOUR_W-1:0] COL_CURSOR = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ITEM_COUNT     = 2'd0,
        CFG_SCROLL_OFFSET  = 2'd1,
        CFG_SELECTED_INDEX = 2'd2,
        CFG_CURSOR_ON      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [X_W-1:0] pixel_x;
        logic [Y_W-1:0] pixel_y;
    } in_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] pixel_colour;
        logic                line_end;
    } out_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  item_count;
        logic [SCROLL_W-1:0] scroll_offset;
        logic [SEL_W-1:0]    selected_index;
        logic                cursor_on;
    } cfg_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] grad;
        logic                line_end;
        logic                bar_x;
        logic                in_col;
        logic [1:0]          col;
        logic [6:0]          dx;
        logic signed [8:0]   view_y;
        logic signed [12:0]  cont_row;
        logic [ROWS_W-1:0]   rows;
    } s1_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] grad;
        logic                line_end;
        logic                bar_on;
        logic                in_col;
        logic [1:0]          col;
        logic [6:0]          dx;
        logic                cy_ok;
        logic [11:0]         cy;
        logic [4:0]          row;
        logic signed [9:0]   vp1;
        logic signed [9:0]   vt;
        logic [11:0]         content;
        logic [18:0]         scaled_scroll;
    } s2_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] grad;
        logic                line_end;
        logic                bar_on;
        logic signed [22:0]  p_lo;
        logic signed [22:0]  p_hi;
        logic [18:0]         scaled_scroll;
        logic                cy_ok;
        logic                in_col;
        logic [6:0]          dx;
        logic [6:0]          rem;
        logic [6:0]          idx;
    } s3_t;

    // Vertical navy gradient; the divisions by 224 reduce to threshold compares.
    function automatic logic [COLOUR_W-1:0] grad_colour(input logic [Y_W-1:0] y);
        logic [7:0] pos;
        logic [9:0] p3;
        logic [1:0] k3;
        logic [2:0] k4;
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
        if (y <= 8'd15) begin
            pos = 8'd0;
        end else if (y >= 8'd239) begin
            pos = 8'd224;
        end else begin
            pos = y - 8'd15;
        end
        p3 = {2'b00, pos} + {1'b0, pos, 1'b0};
        if (p3 >= 10'd672) begin
            k3 = 2'd3;
        end else if (p3 >= 10'd448) begin
            k3 = 2'd2;
        end else if (p3 >= 10'd224) begin
            k3 = 2'd1;
        end else begin
            k3 = 2'd0;
        end
        if (pos >= 8'd224) begin
            k4 = 3'd4;
        end else if (pos >= 8'd168) begin
            k4 = 3'd3;
        end else if (pos >= 8'd112) begin
            k4 = 3'd2;
        end else if (pos >= 8'd56) begin
            k4 = 3'd1;
        end else begin
            k4 = 3'd0;
        end
        r = 5'd1 + {3'b000, k3};
        g = 6'd4 + {4'b0000, k3};
        b = 5'd8 + {2'b00, k4};
        return {r, g, b};
    endfunction

    // Thumb height 202*202 / (rows*100) for the row counts that show a scrollbar.
    function automatic logic [7:0] thumb_len(input logic [ROWS_W-1:0] rows);
        logic [7:0] h;
        case (rows)
            5'd3:    h = 8'd136;
            5'd4:    h = 8'd102;
            5'd5:    h = 8'd81;
            5'd6:    h = 8'd68;
            5'd7:    h = 8'd58;
            5'd8:    h = 8'd51;
            5'd9:    h = 8'd45;
            5'd10:   h = 8'd40;
            5'd11:   h = 8'd37;
            5'd12:   h = 8'd34;
            5'd13:   h = 8'd31;
            5'd14:   h = 8'd29;
            5'd15:   h = 8'd27;
            5'd16:   h = 8'd25;
            5'd17:   h = 8'd24;
            5'd18:   h = 8'd22;
            5'd19:   h = 8'd21;
            5'd20:   h = 8'd20;
            5'd21:   h = 8'd19;
            5'd22:   h = 8'd18;
            default: h = 8'd0;
        endcase
        return h;
    endfunction

    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
        return (c > COUNT_W'(MAX_ITEMS)) ? COUNT_W'(MAX_ITEMS) : c;
    endfunction

endpackage

[sv/icgc_compose.sv]
// Final compositing step: thumb test, cell hit, cursor outline and layer selection.
// Depends on icgc_pkg for the stage record, configuration record and colours.
module icgc_compose (
    input  icgc_pkg::s3_t                     s3,
    input  icgc_pkg::cfg_t                    cfg,
    output logic [icgc_pkg::COLOUR_W-1:0]     colour
);
    import icgc_pkg::*;

    logic signed [22:0]  scaled_x;
    logic                thumb;
    logic [COUNT_W-1:0]  count_eff;
    logic [6:0]          dy;
    logic                cell_hit;
    logic                cursor_hit;

    assign scaled_x  = {4'b0000, s3.scaled_scroll};
    assign thumb     = !(s3.p_lo <= scaled_x) && (s3.p_hi <= scaled_x);
    assign count_eff = clamp_count(cfg.item_count);
    assign dy        = s3.rem - 7'd2;
    assign cell_hit  = s3.cy_ok && s3.in_col && (s3.rem inside {[7'd2:7'd89]})
                       && (s3.idx < count_eff);

    always_comb begin
        cursor_hit = 1'b0;
        if (cfg.cursor_on && (s3.idx == {1'b0, cfg.selected_index})) begin
            if ((dy inside {[7'd3:7'd4]}) || (dy inside {[7'd83:7'd84]})) begin
                cursor_hit = s3.dx inside {[7'd3:7'd86]};
            end else if (dy inside {[7'd5:7'd82]}) begin
                cursor_hit = (s3.dx inside {[7'd3:7'd4]}) || (s3.dx inside {[7'd85:7'd86]});
            end
        end
    end

    always_comb begin
        colour = s3.grad;
        if (s3.bar_on) begin
            colour = thumb ? COL_THUMB : COL_TRACK;
        end
        if (cell_hit) begin
            colour = cursor_hit ? COL_CURSOR : COL_CELL;
        end
    end

endmodule

[sv/icon_grid_scanline_compositor.sv]
// Top level of the icon grid scanline compositor: configuration registers and a
// four-stage pixel pipeline. Depends on icgc_pkg and icgc_compose.
//
// Usage: a pixel request (pixel_x, pixel_y) enters on the s_ channel and its RGB565
// colour with a line-end flag leaves on the m_ channel, in request order. Both
// channels use valid/ready. The pipeline has four register stages, and one pixel
// is taken per clock while the receiver does not stall; the four stages are
// gradient and column decode, row split by reciprocal multiply, the two thumb
// products, and the final layer compositing into the output register.
// When the receiver stalls, each stage holds its contents and empty stages still
// fill, so s_ready drops only once all four stages hold results.
// Configuration is written through cfg_we, cfg_addr and cfg_wdata and must only
// change while no request is in flight. A synchronous reset (aresetn low) empties
// the pipeline and sets item_count, scroll_offset and selected_index to zero and
// cursor_on to one.
module icon_grid_scanline_compositor (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  icgc_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output icgc_pkg::out_t                  m_data,
    input  logic                            cfg_we,
    input  logic [icgc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [icgc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import icgc_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    out_t out_reg, out_next;

    logic [COUNT_W-1:0]  count_eff;
    logic [16:0]         rows_prod;
    logic [24:0]         row_prod;
    logic [11:0]         row_x100;
    logic signed [22:0]  vp1_x, vt_x, cont_x;
    logic [COLOUR_W-1:0] colour;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                CFG_ITEM_COUNT:     cfg_next.item_count     = cfg_wdata[COUNT_W-1:0];
                CFG_SCROLL_OFFSET:  cfg_next.scroll_offset  = cfg_wdata[SCROLL_W-1:0];
                CFG_SELECTED_INDEX: cfg_next.selected_index = cfg_wdata[SEL_W-1:0];
                CFG_CURSOR_ON:      cfg_next.cursor_on      = cfg_wdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{item_count: '0, scroll_offset: '0, selected_index: '0,
                         cursor_on: 1'b1};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = v4_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage 1: gradient, column decode, viewport and content rows.
    assign count_eff = clamp_count(cfg_reg.item_count);
    assign rows_prod = ({10'b0, count_eff} + 17'd2) * 17'd171;

    always_comb begin
        s1_next.grad      = grad_colour(s_data.pixel_y);
        s1_next.line_end  = (s_data.pixel_x == 9'd319);
        s1_next.bar_x     = s_data.pixel_x inside {[9'd314:9'd316]};
        s1_next.view_y    = $signed({1'b0, s_data.pixel_y}) - 9'sd38;
        s1_next.cont_row  = $signed({2'b00, cfg_reg.scroll_offset})
                            + {{4{s1_next.view_y[8]}}, s1_next.view_y};
        s1_next.rows      = rows_prod[9 +: ROWS_W];
        s1_next.in_col    = 1'b1;
        s1_next.col       = 2'd0;
        s1_next.dx        = 7'(s_data.pixel_x - 9'd10);
        if (s_data.pixel_x inside {[9'd10:9'd99]}) begin
            s1_next.col = 2'd0;
            s1_next.dx  = 7'(s_data.pixel_x - 9'd10);
        end else if (s_data.pixel_x inside {[9'd115:9'd204]}) begin
            s1_next.col = 2'd1;
            s1_next.dx  = 7'(s_data.pixel_x - 9'd115);
        end else if (s_data.pixel_x inside {[9'd220:9'd309]}) begin
            s1_next.col = 2'd2;
            s1_next.dx  = 7'(s_data.pixel_x - 9'd220);
        end else begin
            s1_next.in_col = 1'b0;
        end
    end

    // Stage 2: content height, thumb height, row split and scaled scroll.
    assign row_prod = {13'b0, s1_reg.cont_row[11:0]} * 25'd5243;

    always_comb begin
        s2_next.grad          = s1_reg.grad;
        s2_next.line_end      = s1_reg.line_end;
        s2_next.bar_on        = s1_reg.bar_x && (s1_reg.rows >= ROWS_W'(3));
        s2_next.in_col        = s1_reg.in_col;
        s2_next.col           = s1_reg.col;
        s2_next.dx            = s1_reg.dx;
        s2_next.cy_ok         = !s1_reg.cont_row[12];
        s2_next.cy            = s1_reg.cont_row[11:0];
        s2_next.row           = row_prod[19 +: 5];
        s2_next.vp1           = {s1_reg.view_y[8], s1_reg.view_y} + 10'sd1;
        s2_next.vt            = {s1_reg.view_y[8], s1_reg.view_y}
                                - $signed({2'b00, thumb_len(s1_reg.rows)}) + 10'sd1;
        s2_next.content       = 12'(s1_reg.rows) * 12'd100;
        s2_next.scaled_scroll = 19'(cfg_reg.scroll_offset) * 19'd202;
    end

    // Stage 3: thumb boundary products, in-cell row offset and cell index.
    assign vp1_x    = {{13{s2_reg.vp1[9]}}, s2_reg.vp1};
    assign vt_x     = {{13{s2_reg.vt[9]}}, s2_reg.vt};
    assign cont_x   = {11'b0, s2_reg.content};
    assign row_x100 = 12'(s2_reg.row) * 12'd100;

    always_comb begin
        s3_next.grad          = s2_reg.grad;
        s3_next.line_end      = s2_reg.line_end;
        s3_next.bar_on        = s2_reg.bar_on;
        s3_next.p_lo          = vp1_x * cont_x;
        s3_next.p_hi          = vt_x * cont_x;
        s3_next.scaled_scroll = s2_reg.scaled_scroll;
        s3_next.cy_ok         = s2_reg.cy_ok;
        s3_next.in_col        = s2_reg.in_col;
        s3_next.dx            = s2_reg.dx;
        s3_next.rem           = 7'(s2_reg.cy - row_x100);
        s3_next.idx           = {2'b00, s2_reg.row} + {1'b0, s2_reg.row, 1'b0}
                                + {5'b00000, s2_reg.col};
    end

    // Stage 4: layer compositing into the output register.
    icgc_compose u_compose (
        .s3     (s3_reg),
        .cfg    (cfg_reg),
        .colour (colour)
    );

    always_comb begin
        out_next.pixel_colour = colour;
        out_next.line_end     = s3_reg.line_end;
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_reg <= s1_next;
        end
        if (rdy2) begin
            s2_reg <= s2_next;
        end
        if (rdy3) begin
            s3_reg <= s3_next;
        end
        if (rdy4) begin
            out_reg <= out_next;
        end
    end

endmodule

[sv/icgc_checker.sv]
// Port-level checker for the icon grid scanline compositor, bound to the top level.
// Depends on icgc_pkg for the payload types.
module icgc_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input icgc_pkg::out_t m_data
);
    import icgc_pkg::*;

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    // A reset cycle leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // A ready receiver lets the pipeline take a new request.
    a_ready_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("request refused while receiver ready");

    // With the receiver ready throughout, an accepted request is followed by m_valid.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && m_ready) ##1 m_ready ##1 m_ready ##1 m_ready
        |=> m_valid)
        else $error("result missing four cycles after request");

endmodule

bind icon_grid_scanline_compositor icgc_checker u_icgc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[tb/tb_icon_grid_scanline_compositor.sv]
`timescale 1ns / 100ps
// Self-checking testbench for icon_grid_scanline_compositor: directed, back-pressure and
// random pixel requests are checked against an in-bench colour predictor. Needs icgc_pkg.
module tb_icon_grid_scanline_compositor;
    import icgc_pkg::*;

    localparam int CLAMP_ITEMS  = 64;
    localparam int TOP_ROW      = 38;
    localparam int VIEW_ROWS    = 202;
    localparam int TILE_W       = 90;
    localparam int TILE_H       = 88;
    localparam int TILE_X0      = 10;
    localparam int TILE_XSTEP   = 105;
    localparam int TILE_YSTEP   = 100;
    localparam int TILE_PAD     = 2;
    localparam int RING_INSET   = 3;
    localparam int RING_WIDTH   = 2;
    localparam int BAR_LEFT     = 314;
    localparam int BAR_RIGHT    = 316;
    localparam int LINE_LAST    = 319;
    localparam logic [15:0] TILE_RGB   = 16'h320D;
    localparam logic [15:0] TRACK_RGB  = 16'h2145;
    localparam logic [15:0] THUMB_RGB  = 16'h8410;
    localparam logic [15:0] RING_RGB   = 16'hFFFF;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 12;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int SWEEP_STEPS  = 24;
    localparam int SWEEP_PIXELS = 60;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    cfg_t grid_cfg;
    out_t expected_pixels[$];
    int   error_count;
    int   checked_count;
    int   settings_count;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_requests;
    int   hold_seen;
    int   hold_left;

    icon_grid_scanline_compositor DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    function automatic logic [15:0] navy_gradient(input int y);
        int pos;
        int r;
        int g;
        int b;
        pos = (y <= 15) ? 0 : ((y >= 239) ? 224 : y - 15);
        r = 1 + (3 * pos) / 224;
        g = 4 + (3 * pos) / 224;
        b = 8 + (4 * pos) / 224;
        return 16'((r << 11) | (g << 5) | b);
    endfunction

    function automatic out_t shade_pixel(input in_t px);
        int x;
        int y;
        int count;
        int scroll;
        int sel;
        int content;
        int view_y;
        int cy;
        int thumb_h;
        int thumb_top;
        int row;
        int dy;
        int col;
        int idx;
        int x0;
        int x1;
        int last;
        bit past_end;
        logic [15:0] colour;
        out_t res;
        x = px.pixel_x;
        y = px.pixel_y;
        scroll = grid_cfg.scroll_offset;
        sel = grid_cfg.selected_index;
        count = (grid_cfg.item_count > CLAMP_ITEMS) ? CLAMP_ITEMS : grid_cfg.item_count;
        content = ((count + 2) / 3) * TILE_YSTEP;
        view_y = y - TOP_ROW;
        cy = view_y + scroll;
        colour = navy_gradient(y);
        if (x <= LINE_LAST) begin
            if (content > VIEW_ROWS && x >= BAR_LEFT && x <= BAR_RIGHT) begin
                thumb_h = (VIEW_ROWS * VIEW_ROWS) / content;
                thumb_top = (scroll * VIEW_ROWS) / content;
                colour = (view_y >= thumb_top && view_y < thumb_top + thumb_h) ?
                         THUMB_RGB : TRACK_RGB;
            end
            if (cy >= 0) begin
                row = cy / TILE_YSTEP;
                dy = (cy % TILE_YSTEP) - TILE_PAD;
                if (dy >= 0 && dy < TILE_H) begin
                    past_end = 1'b0;
                    last = TILE_H - 1 - RING_INSET;
                    for (col = 0; col < 3; col++) begin
                        idx = row * 3 + col;
                        x0 = TILE_X0 + col * TILE_XSTEP;
                        x1 = x0 + TILE_W - 1;
                        if (idx >= count) begin
                            past_end = 1'b1;
                        end
                        if (!past_end && x >= x0 && x <= x1) begin
                            colour = TILE_RGB;
                            if (grid_cfg.cursor_on && idx == sel) begin
                                if ((dy >= RING_INSET && dy < RING_INSET + RING_WIDTH) ||
                                    (dy <= last && dy > last - RING_WIDTH)) begin
                                    if (x >= x0 + RING_INSET && x <= x1 - RING_INSET) begin
                                        colour = RING_RGB;
                                    end
                                end else if (dy >= RING_INSET + RING_WIDTH &&
                                             dy <= last - RING_WIDTH) begin
                                    if ((x >= x0 + RING_INSET &&
                                         x < x0 + RING_INSET + RING_WIDTH) ||
                                        (x > x1 - RING_INSET - RING_WIDTH &&
                                         x <= x1 - RING_INSET)) begin
                                        colour = RING_RGB;
                                    end
                                end
                            end
                        end
                    end
                end
            end
        end
        res.pixel_colour = colour;
        res.line_end = (x == LINE_LAST);
        return res;
    endfunction

    // Mostly in-view pixels, with a share aimed at the selected tile and the scrollbar.
    function automatic in_t pick_pixel();
        int pick;
        int sel;
        int tile_x;
        int tile_y;
        in_t px;
        pick = $urandom_range(99);
        sel = grid_cfg.selected_index;
        px.pixel_x = 9'($urandom_range(LINE_LAST));
        px.pixel_y = 8'($urandom_range(239, TOP_ROW));
        if (pick < 25) begin
            tile_x = TILE_X0 + (sel % 3) * TILE_XSTEP + $urandom_range(TILE_W + 3) - 2;
            tile_y = TOP_ROW + (sel / 3) * TILE_YSTEP + TILE_PAD - grid_cfg.scroll_offset
                     + $urandom_range(TILE_H + 3) - 2;
            px.pixel_x = 9'(tile_x);
            if (tile_y >= 0 && tile_y <= 255) begin
                px.pixel_y = 8'(tile_y);
            end
        end else if (pick < 35) begin
            px.pixel_x = 9'($urandom_range(LINE_LAST, BAR_LEFT - 2));
        end else if (pick < 45) begin
            px.pixel_x = 9'($urandom_range(511));
            px.pixel_y = 8'($urandom_range(255));
        end
        return px;
    endfunction

    task automatic set_pacing(input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic send_pixel(input logic [8:0] x, input logic [7:0] y);
        in_t px;
        px.pixel_x = x;
        px.pixel_y = y;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= px;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        expected_pixels.push_back(shade_pixel(px));
        @(negedge aclk);
    endtask

    task automatic send_random_pixel();
        in_t px;
        px = pick_pixel();
        send_pixel(px.pixel_x, px.pixel_y);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_pixels.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic program_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_ITEM_COUNT: begin
                grid_cfg.item_count = val[COUNT_W-1:0];
            end
            CFG_SCROLL_OFFSET: begin
                grid_cfg.scroll_offset = val[SCROLL_W-1:0];
            end
            CFG_SELECTED_INDEX: begin
                grid_cfg.selected_index = val[SEL_W-1:0];
            end
            default: begin
                grid_cfg.cursor_on = val[0];
            end
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure_grid(input int count, input int scroll, input int sel,
                                  input int cursor);
        wait_idle();
        program_register(CFG_ITEM_COUNT, CFG_DATA_W'(count));
        program_register(CFG_SCROLL_OFFSET, CFG_DATA_W'(scroll));
        program_register(CFG_SELECTED_INDEX, CFG_DATA_W'(sel));
        program_register(CFG_CURSOR_ON, CFG_DATA_W'(cursor));
        settings_count++;
    endtask

    task automatic test_reset_values();
        send_pixel(9'd0, 8'd38);
        send_pixel(9'd12, 8'd43);
        send_pixel(9'd319, 8'd239);
        wait_idle();
    endtask

    task automatic test_directed_layers();
        configure_grid(7, 0, 4, 1);
        send_pixel(9'd315, 8'd38);
        send_pixel(9'd315, 8'd200);
        send_pixel(9'd313, 8'd100);
        send_pixel(9'd10, 8'd40);
        send_pixel(9'd99, 8'd127);
        send_pixel(9'd118, 8'd143);
        send_pixel(9'd118, 8'd145);
        send_pixel(9'd120, 8'd145);
        send_pixel(9'd204, 8'd143);
        send_pixel(9'd201, 8'd224);
        send_pixel(9'd100, 8'd100);
        send_pixel(9'd320, 8'd100);
        send_pixel(9'd511, 8'd255);
        send_pixel(9'd0, 8'd0);
        send_pixel(9'd315, 8'd20);
        send_pixel(9'd200, 8'd255);
    endtask

    task automatic test_config_extremes();
        configure_grid(127, 2047, 63, 0);
        send_pixel(9'd315, 8'd100);
        send_pixel(9'd50, 8'd238);
        configure_grid(64, 1900, 63, 1);
        send_pixel(9'd230, 8'd45);
        send_pixel(9'd315, 8'd239);
        configure_grid(3, 0, 0, 0);
        send_pixel(9'd12, 8'd43);
        send_pixel(9'd315, 8'd43);
    endtask

    // The receiver holds off while requests keep coming, so the pipeline fills and
    // s_ready drops; afterwards the sender waits for every result before going on.
    task automatic test_backpressure();
        int k;
        configure_grid(20, 50, 7, 1);
        set_pacing(0, 0);
        hold_requests++;
        for (k = 0; k < 40; k++) begin
            send_random_pixel();
        end
        wait_idle();
    endtask

    task automatic test_random_sweep();
        int step;
        int k;
        int count;
        int content;
        int scroll;
        int counts[8];
        counts = '{0, 1, 3, 6, 7, 64, 65, 127};
        for (step = 0; step < SWEEP_STEPS; step++) begin
            count = (step < 8) ? counts[step] : $urandom_range(127);
            content = (((count > CLAMP_ITEMS ? CLAMP_ITEMS : count) + 2) / 3) * TILE_YSTEP;
            if (step % 6 == 5) begin
                scroll = 2047;
            end else if (step % 6 == 0) begin
                scroll = 0;
            end else if (step % 6 == 4) begin
                scroll = $urandom_range(2047);
            end else begin
                scroll = $urandom_range(content);
            end
            wait_idle();
            program_register(CFG_ITEM_COUNT,
                             CFG_DATA_W'(count | ($urandom_range(15) << COUNT_W)));
            program_register(CFG_SCROLL_OFFSET, CFG_DATA_W'(scroll));
            program_register(CFG_SELECTED_INDEX,
                             CFG_DATA_W'((step == 7) ? 63 :
                                         ($urandom_range(1) ? $urandom_range(63) :
                                          $urandom_range(count > 0 ? count - 1 : 0, 0))
                                         | ($urandom_range(31) << SEL_W)));
            program_register(CFG_CURSOR_ON,
                             CFG_DATA_W'(((step % 5) != 3) | ($urandom_range(1023) << 1)));
            settings_count++;
            case (step % 4)
                0: set_pacing(0, 0);
                1: set_pacing(55, 0);
                2: set_pacing(0, 55);
                default: set_pacing(18, 18);
            endcase
            for (k = 0; k < SWEEP_PIXELS; k++) begin
                send_random_pixel();
            end
        end
    endtask

    always @(negedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected result: pixel_colour %h, line_end %b",
                       m_data.pixel_colour, m_data.line_end);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                checked_count++;
                if (m_data.pixel_colour !== want.pixel_colour) begin
                    $error("pixel_colour mismatch: expected %h, got %h",
                           want.pixel_colour, m_data.pixel_colour);
                    error_count++;
                end
                if (m_data.line_end !== want.line_end) begin
                    $error("line_end mismatch: expected %b, got %b",
                           want.line_end, m_data.line_end);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        error_count = 0;
        checked_count = 0;
        settings_count = 0;
        cycle_count = 0;
        hold_requests = 0;
        hold_seen = 0;
        hold_left = 0;
        grid_cfg.item_count = '0;
        grid_cfg.scroll_offset = '0;
        grid_cfg.selected_index = '0;
        grid_cfg.cursor_on = 1'b1;
        set_pacing(0, 0);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_values();
        test_directed_layers();
        test_config_extremes();
        test_backpressure();
        test_random_sweep();

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (expected_pixels.size() != 0) begin
            $error("%0d expected results never arrived", expected_pixels.size());
            error_count++;
        end
        $display("Checked %0d pixel results across %0d grid settings, with idle, stall and",
                 checked_count, settings_count);
        $display("hold-off phases and pixels past the line and outside the viewport.");
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
